@@ hdl/tpd_pkg.sv @@
// shared constants and types of the triangle plane dedup table
package tpd_pkg;

  localparam int TABLE_DEPTH_DEF = 512;
  localparam int OPND_W = 33;
  localparam int ACC_W = 66;
  localparam int TOL_W = 16;
  localparam logic [TOL_W-1:0] TOL_RESET = 16'd26;
  localparam logic [9:0] PLANE_NONE = 10'h3FF;

  typedef struct packed {
    logic                    first;
    logic signed [OPND_W-1:0] a;
    logic signed [OPND_W-1:0] b;
    logic signed [ACC_W-1:0]  bias;
  } mac_req_t;

endpackage

@@ hdl/tpd_ifs.sv @@
// triangle and plane channel interfaces
interface tpd_tri_if;
  logic               valid;
  logic               ready;
  logic               start_new_mesh;
  logic signed [31:0] p1_x;
  logic signed [31:0] p1_y;
  logic signed [31:0] p1_z;
  logic signed [31:0] p2_x;
  logic signed [31:0] p2_y;
  logic signed [31:0] p2_z;
  logic signed [31:0] p3_x;
  logic signed [31:0] p3_y;
  logic signed [31:0] p3_z;
  modport source (output valid, start_new_mesh, p1_x, p1_y, p1_z, p2_x, p2_y, p2_z,
                  p3_x, p3_y, p3_z, input ready);
  modport sink (input valid, start_new_mesh, p1_x, p1_y, p1_z, p2_x, p2_y, p2_z,
                p3_x, p3_y, p3_z, output ready);
endinterface

interface tpd_plane_if;
  logic              valid;
  logic              ready;
  logic signed [9:0] plane_index;
  logic              plane_added;
  logic              degenerate;
  logic              table_full;
  logic [2:0]        normal_sign_bits;
  modport source (output valid, plane_index, plane_added, degenerate, table_full,
                  normal_sign_bits, input ready);
  modport sink (input valid, plane_index, plane_added, degenerate, table_full,
                normal_sign_bits, output ready);
endinterface

@@ hdl/triangle_plane_dedup_table.sv @@
// top level: plane equation of a triangle and lookup in the plane table
//
// one triangle transaction in on "triangle", one result transaction out on
// "plane". the block takes a triangle only while it is idle, then works
// on it alone: edge differences are scaled one bit a cycle, the cross
// product runs on the shared multiplier, the normalizing shift takes one
// bit a cycle, then come the sum of squares, the root, the three divides
// and the distance. the table scan then runs over the stored planes, with
// early exit on a facing or distance miss; the pace is set by the single
// multiplier and the bit-serial root/divide. the result sits in an output
// register; if the receiver stalls it holds there and a new triangle can
// still be taken and worked on, the next result waits until the register
// frees. reset (rst, synchronous) empties the table and sets the
// tolerance to 26; table entries are not cleared, only the plane count.
// cfg_write/cfg_data load the tolerance.
module triangle_plane_dedup_table #(
  parameter int TABLE_DEPTH = tpd_pkg::TABLE_DEPTH_DEF
) (
  input  logic                       clk,
  input  logic                       rst,
  input  logic                       cfg_write,
  input  logic [tpd_pkg::TOL_W-1:0]  cfg_data,
  tpd_tri_if.sink                    triangle,
  tpd_plane_if.source                plane
);

  localparam int IW = (TABLE_DEPTH > 1) ? $clog2(TABLE_DEPTH) : 1;
  localparam int CW = $clog2(TABLE_DEPTH + 1);
  localparam logic [CW-1:0] DEPTH_C = CW'(TABLE_DEPTH);

  localparam logic [3:0] S_IDLE  = 4'd0;
  localparam logic [3:0] S_DIFF  = 4'd1;
  localparam logic [3:0] S_SCALE = 4'd2;
  localparam logic [3:0] S_CROSS = 4'd3;
  localparam logic [3:0] S_CNORM = 4'd4;
  localparam logic [3:0] S_SQ    = 4'd5;
  localparam logic [3:0] S_SQRT  = 4'd6;
  localparam logic [3:0] S_DIV   = 4'd7;
  localparam logic [3:0] S_DIST  = 4'd8;
  localparam logic [3:0] S_RD    = 4'd9;
  localparam logic [3:0] S_MATCH = 4'd10;
  localparam logic [3:0] S_OUT   = 4'd11;

  typedef struct packed {
    logic signed [17:0] nx;
    logic signed [17:0] ny;
    logic signed [17:0] nz;
    logic signed [31:0] pdist;
  } plane_entry_t;

  // sequencer
  logic [3:0]                state;
  logic [3:0]                step;
  logic [1:0]                kc;
  logic [tpd_pkg::TOL_W-1:0] tol;
  logic [CW-1:0]             count;
  logic [CW-1:0]             idx;

  // triangle and working values
  logic signed [31:0] p1 [3];
  logic signed [31:0] p2 [3];
  logic signed [31:0] p3 [3];
  logic [32:0]        dmag [6];
  logic               dneg [6];
  logic signed [32:0] diff [6];
  logic signed [32:0] sd [6];
  logic [61:0]        cmag [3];
  logic               cneg [3];
  logic signed [17:0] nrm [3];
  logic [2:0]         sb;
  logic signed [31:0] plane_dist;

  // result waiting for the output register
  logic [9:0] res_index;
  logic       res_added;
  logic       res_degen;
  logic       res_full;
  logic [2:0] res_sb;
  logic       out_valid;

  // plane table
  plane_entry_t mem [TABLE_DEPTH];
  plane_entry_t rd;
  logic         mem_re;
  logic         mem_we;

  // shared arithmetic
  tpd_pkg::mac_req_t                req;
  logic signed [tpd_pkg::ACC_W-1:0] acc;
  logic [tpd_pkg::ACC_W-1:0]        acc_mag;
  logic [tpd_pkg::ACC_W-1:0]        rnd;
  logic signed [tpd_pkg::ACC_W-1:0] dbias;
  logic                             in_tol;
  logic                             sqrt_start;
  logic                             sqrt_done;
  logic [31:0]                      root;
  logic                             div_start;
  logic                             div_done;
  logic [47:0]                      quotient;
  logic [47:0]                      dividend;
  logic [1:0]                       kd;
  logic [61:0]                      cm_kd;
  logic [17:0]                      q;
  logic                             any_hi;
  logic                             all_lo;
  logic                             all_zero;
  logic [CW+9:0]                    idx_wide;

  tpd_mac u_mac (.clk(clk), .req(req), .acc(acc));

  tpd_sqrt u_sqrt (
    .clk(clk), .rst(rst), .start(sqrt_start), .radicand(acc[63:0]),
    .root(root), .done(sqrt_done)
  );

  tpd_div u_div (
    .clk(clk), .rst(rst), .start(div_start), .dividend(dividend),
    .divisor(root), .quotient(quotient), .done(div_done)
  );

  assign triangle.ready         = (state == S_IDLE);
  assign plane.valid            = out_valid;

  assign acc_mag  = acc[tpd_pkg::ACC_W-1] ? tpd_pkg::ACC_W'(-acc) : acc;
  assign rnd      = (acc_mag + tpd_pkg::ACC_W'(32768)) >> 16;
  assign dbias    = -($signed({{34{rd.pdist[31]}}, rd.pdist}) <<< 16);
  assign in_tol   = acc_mag <= {{(tpd_pkg::ACC_W-32){1'b0}}, tol, 16'b0};
  assign q        = quotient[17:0];
  assign idx_wide = {10'b0, idx};

  // edge differences and their scaled signed forms
  always_comb begin
    for (int k = 0; k < 3; k++) begin
      diff[k]     = {p2[k][31], p2[k]} - {p1[k][31], p1[k]};
      diff[k + 3] = {p3[k][31], p3[k]} - {p1[k][31], p1[k]};
    end
    for (int i = 0; i < 6; i++) begin
      sd[i] = dneg[i] ? -$signed({3'b0, dmag[i][29:0]}) : $signed({3'b0, dmag[i][29:0]});
    end
  end

  // normalizing shift decisions over the three cross magnitudes
  always_comb begin
    any_hi   = 1'b0;
    all_lo   = 1'b1;
    all_zero = 1'b1;
    for (int j = 0; j < 3; j++) begin
      any_hi   = any_hi | (|cmag[j][61:31]);
      all_lo   = all_lo & ~(|cmag[j][61:30]);
      all_zero = all_zero & ~(|cmag[j]);
    end
  end

  // divider operands: first component after the root, then the next one
  assign kd = (state == S_DIV) ? kc + 2'd1 : 2'd0;
  always_comb begin
    case (kd)
      2'd1:    cm_kd = cmag[1];
      2'd2:    cm_kd = cmag[2];
      default: cm_kd = cmag[0];
    endcase
  end
  assign dividend   = {1'b0, cm_kd[30:0], 16'b0} + {17'b0, root[31:1]};
  assign sqrt_start = (state == S_SQ) && (step == 4'd3);
  assign div_start  = ((state == S_SQRT) && sqrt_done) ||
                      ((state == S_DIV) && div_done && (kc != 2'd2));

  // operand schedule of the shared multiplier
  always_comb begin
    req = '0;
    unique case (state)
      S_CROSS: begin
        case (step)
          4'd0: begin req.a = sd[4];  req.b = sd[2]; req.first = 1'b1; end
          4'd1: begin req.a = -sd[5]; req.b = sd[1]; end
          4'd2: begin req.a = sd[5];  req.b = sd[0]; req.first = 1'b1; end
          4'd3: begin req.a = -sd[3]; req.b = sd[2]; end
          4'd4: begin req.a = sd[3];  req.b = sd[1]; req.first = 1'b1; end
          4'd5: begin req.a = -sd[4]; req.b = sd[0]; end
          default: ;
        endcase
      end
      S_SQ: begin
        case (step)
          4'd0: begin
            req.a = $signed({2'b0, cmag[0][30:0]});
            req.b = $signed({2'b0, cmag[0][30:0]});
            req.first = 1'b1;
          end
          4'd1: begin
            req.a = $signed({2'b0, cmag[1][30:0]});
            req.b = $signed({2'b0, cmag[1][30:0]});
          end
          4'd2: begin
            req.a = $signed({2'b0, cmag[2][30:0]});
            req.b = $signed({2'b0, cmag[2][30:0]});
          end
          default: ;
        endcase
      end
      S_DIST: begin
        case (step)
          4'd0: begin
            req.a = {p1[0][31], p1[0]}; req.b = {{15{nrm[0][17]}}, nrm[0]};
            req.first = 1'b1;
          end
          4'd1: begin req.a = {p1[1][31], p1[1]}; req.b = {{15{nrm[1][17]}}, nrm[1]}; end
          4'd2: begin req.a = {p1[2][31], p1[2]}; req.b = {{15{nrm[2][17]}}, nrm[2]}; end
          default: ;
        endcase
      end
      S_MATCH: begin
        case (step)
          4'd0: begin
            req.a = {{15{nrm[0][17]}}, nrm[0]}; req.b = {{15{rd.nx[17]}}, rd.nx};
            req.first = 1'b1;
          end
          4'd1: begin
            req.a = {{15{nrm[1][17]}}, nrm[1]}; req.b = {{15{rd.ny[17]}}, rd.ny};
          end
          4'd2: begin
            req.a = {{15{nrm[2][17]}}, nrm[2]}; req.b = {{15{rd.nz[17]}}, rd.nz};
          end
          4'd3: begin
            req.a = {p1[0][31], p1[0]}; req.b = {{15{rd.nx[17]}}, rd.nx};
            req.first = 1'b1; req.bias = dbias;
          end
          4'd4: begin req.a = {p1[1][31], p1[1]}; req.b = {{15{rd.ny[17]}}, rd.ny}; end
          4'd5: begin req.a = {p1[2][31], p1[2]}; req.b = {{15{rd.nz[17]}}, rd.nz}; end
          4'd6: begin
            req.a = {p2[0][31], p2[0]}; req.b = {{15{rd.nx[17]}}, rd.nx};
            req.first = 1'b1; req.bias = dbias;
          end
          4'd7: begin req.a = {p2[1][31], p2[1]}; req.b = {{15{rd.ny[17]}}, rd.ny}; end
          4'd8: begin req.a = {p2[2][31], p2[2]}; req.b = {{15{rd.nz[17]}}, rd.nz}; end
          4'd9: begin
            req.a = {p3[0][31], p3[0]}; req.b = {{15{rd.nx[17]}}, rd.nx};
            req.first = 1'b1; req.bias = dbias;
          end
          4'd10: begin req.a = {p3[1][31], p3[1]}; req.b = {{15{rd.ny[17]}}, rd.ny}; end
          4'd11: begin req.a = {p3[2][31], p3[2]}; req.b = {{15{rd.nz[17]}}, rd.nz}; end
          default: ;
        endcase
      end
      default: ;
    endcase
  end

  // table reads while scanning, one append when nothing matched and the table has room
  assign mem_re = (state == S_RD) && (idx != count);
  assign mem_we = (state == S_RD) && (idx == count) && (count < DEPTH_C);

  always_ff @(posedge clk) begin
    if (mem_re) begin
      rd <= mem[idx[IW-1:0]];
    end
    if (mem_we) begin
      mem[count[IW-1:0]] <= '{nx: nrm[0], ny: nrm[1], nz: nrm[2], pdist: plane_dist};
    end
  end

  // tolerance register
  always_ff @(posedge clk) begin
    if (rst) begin
      tol <= tpd_pkg::TOL_RESET;
    end else if (cfg_write) begin
      tol <= cfg_data;
    end
  end

  // output register, freed by the receiver
  always_ff @(posedge clk) begin
    if (rst) begin
      out_valid <= 1'b0;
    end else if (state == S_OUT && (!out_valid || plane.ready)) begin
      out_valid              <= 1'b1;
      plane.plane_index      <= res_index;
      plane.plane_added      <= res_added;
      plane.degenerate       <= res_degen;
      plane.table_full       <= res_full;
      plane.normal_sign_bits <= res_sb;
    end else if (plane.ready) begin
      out_valid <= 1'b0;
    end
  end

  // sequencer
  always_ff @(posedge clk) begin
    if (rst) begin
      state <= S_IDLE;
      count <= '0;
      step  <= '0;
      kc    <= '0;
    end else begin
      unique case (state)
        S_IDLE: begin
          if (triangle.valid) begin
            p1[0] <= triangle.p1_x; p1[1] <= triangle.p1_y; p1[2] <= triangle.p1_z;
            p2[0] <= triangle.p2_x; p2[1] <= triangle.p2_y; p2[2] <= triangle.p2_z;
            p3[0] <= triangle.p3_x; p3[1] <= triangle.p3_y; p3[2] <= triangle.p3_z;
            if (triangle.start_new_mesh) begin
              count <= '0;
            end
            state <= S_DIFF;
          end
        end
        S_DIFF: begin
          for (int i = 0; i < 6; i++) begin
            dneg[i] <= diff[i][32];
            dmag[i] <= diff[i][32] ? 33'(-diff[i]) : diff[i];
          end
          state <= S_SCALE;
        end
        S_SCALE: begin
          // shift every magnitude right until the largest is below 2^30
          if ((|dmag[0][32:30]) || (|dmag[1][32:30]) || (|dmag[2][32:30]) ||
              (|dmag[3][32:30]) || (|dmag[4][32:30]) || (|dmag[5][32:30])) begin
            for (int i = 0; i < 6; i++) begin
              dmag[i] <= dmag[i] >> 1;
            end
          end else begin
            step  <= '0;
            state <= S_CROSS;
          end
        end
        S_CROSS: begin
          // each component is taken from the accumulator in the cycle after its last term
          if (step == 4'd2 || step == 4'd4 || step == 4'd6) begin
            cmag[step[2:1] - 2'd1] <= acc_mag[61:0];
            cneg[step[2:1] - 2'd1] <= acc[tpd_pkg::ACC_W-1];
          end
          if (step == 4'd6) begin
            state <= S_CNORM;
          end
          step <= step + 4'd1;
        end
        S_CNORM: begin
          if (all_zero) begin
            res_index <= tpd_pkg::PLANE_NONE;
            res_added <= 1'b0;
            res_degen <= 1'b1;
            res_full  <= 1'b0;
            res_sb    <= '0;
            state     <= S_OUT;
          end else if (any_hi) begin
            for (int j = 0; j < 3; j++) begin
              cmag[j] <= cmag[j] >> 1;
            end
          end else if (all_lo) begin
            for (int j = 0; j < 3; j++) begin
              cmag[j] <= cmag[j] << 1;
            end
          end else begin
            step  <= '0;
            state <= S_SQ;
          end
        end
        S_SQ: begin
          // sum of squares handed to the root unit on the last step
          step <= step + 4'd1;
          if (step == 4'd3) begin
            state <= S_SQRT;
          end
        end
        S_SQRT: begin
          if (sqrt_done) begin
            kc    <= '0;
            state <= S_DIV;
          end
        end
        S_DIV: begin
          if (div_done) begin
            nrm[kc] <= cneg[kc] ? -$signed(q) : $signed(q);
            sb[kc]  <= cneg[kc] && (q != '0);
            if (kc == 2'd2) begin
              step  <= '0;
              state <= S_DIST;
            end else begin
              kc <= kc + 2'd1;
            end
          end
        end
        S_DIST: begin
          step <= step + 4'd1;
          if (step == 4'd3) begin
            // round the q.24 dot product to q.8, saturated
            if (acc[tpd_pkg::ACC_W-1]) begin
              plane_dist <= (rnd > tpd_pkg::ACC_W'(33'h80000000)) ? 32'sh80000000
                                                                   : 32'(-rnd);
            end else begin
              plane_dist <= (rnd > tpd_pkg::ACC_W'(32'h7FFFFFFF)) ? 32'sh7FFFFFFF
                                                                   : $signed(rnd[31:0]);
            end
            idx   <= '0;
            state <= S_RD;
          end
        end
        S_RD: begin
          if (idx != count) begin
            step  <= '0;
            state <= S_MATCH;
          end else begin
            res_degen <= 1'b0;
            res_sb    <= sb;
            if (count < DEPTH_C) begin
              res_index <= idx_wide[9:0];
              res_added <= 1'b1;
              res_full  <= 1'b0;
              count     <= count + CW'(1);
            end else begin
              res_index <= tpd_pkg::PLANE_NONE;
              res_added <= 1'b0;
              res_full  <= 1'b1;
            end
            state <= S_OUT;
          end
        end
        S_MATCH: begin
          step <= step + 4'd1;
          // facing test, then one distance test per point
          if ((step == 4'd3 && acc[tpd_pkg::ACC_W-1]) ||
              ((step == 4'd6 || step == 4'd9 || step == 4'd12) && !in_tol)) begin
            idx   <= idx + CW'(1);
            state <= S_RD;
          end else if (step == 4'd12) begin
            res_index <= idx_wide[9:0];
            res_added <= 1'b0;
            res_degen <= 1'b0;
            res_full  <= 1'b0;
            res_sb    <= sb;
            state     <= S_OUT;
          end
        end
        S_OUT: begin
          if (!out_valid || plane.ready) begin
            state <= S_IDLE;
          end
        end
        default: state <= S_IDLE;
      endcase
    end
  end

endmodule

@@ hdl/tpd_mac.sv @@
// shared multiply-accumulate unit, one product accumulated per cycle
module tpd_mac (
  input  logic                                clk,
  input  tpd_pkg::mac_req_t                   req,
  output logic signed [tpd_pkg::ACC_W-1:0]    acc
);

  logic signed [tpd_pkg::ACC_W-1:0] prod;

  assign prod = req.a * req.b;

  always_ff @(posedge clk) begin
    if (req.first) begin
      acc <= req.bias + prod;
    end else begin
      acc <= acc + prod;
    end
  end

endmodule

@@ hdl/tpd_sqrt.sv @@
// iterative integer square root, two radicand bits per cycle
module tpd_sqrt (
  input  logic        clk,
  input  logic        rst,
  input  logic        start,
  input  logic [63:0] radicand,
  output logic [31:0] root,
  output logic        done
);

  logic [63:0] x;
  logic [33:0] rem;
  logic [4:0]  cnt;
  logic        busy;
  logic [33:0] rem_sh;
  logic [33:0] trial;

  assign rem_sh = {rem[31:0], x[63:62]};
  assign trial  = {root, 2'b01};

  always_ff @(posedge clk) begin
    if (rst) begin
      busy <= 1'b0;
      done <= 1'b0;
    end else begin
      done <= 1'b0;
      if (start && !busy) begin
        busy <= 1'b1;
        cnt  <= '0;
        x    <= radicand;
        rem  <= '0;
        root <= '0;
      end else if (busy) begin
        x <= {x[61:0], 2'b00};
        if (rem_sh >= trial) begin
          rem  <= rem_sh - trial;
          root <= {root[30:0], 1'b1};
        end else begin
          rem  <= rem_sh;
          root <= {root[30:0], 1'b0};
        end
        cnt <= cnt + 5'd1;
        if (cnt == 5'd31) begin
          busy <= 1'b0;
          done <= 1'b1;
        end
      end
    end
  end

endmodule

@@ hdl/tpd_div.sv @@
// iterative restoring divider, one quotient bit per cycle
module tpd_div (
  input  logic        clk,
  input  logic        rst,
  input  logic        start,
  input  logic [47:0] dividend,
  input  logic [31:0] divisor,
  output logic [47:0] quotient,
  output logic        done
);

  logic [31:0] rem;
  logic [31:0] dvs;
  logic [5:0]  cnt;
  logic        busy;
  logic [32:0] r_sh;

  assign r_sh = {rem, quotient[47]};

  always_ff @(posedge clk) begin
    if (rst) begin
      busy <= 1'b0;
      done <= 1'b0;
    end else begin
      done <= 1'b0;
      if (start && !busy) begin
        busy     <= 1'b1;
        cnt      <= '0;
        rem      <= '0;
        dvs      <= divisor;
        quotient <= dividend;
      end else if (busy) begin
        if (r_sh >= {1'b0, dvs}) begin
          rem      <= 32'(r_sh - {1'b0, dvs});
          quotient <= {quotient[46:0], 1'b1};
        end else begin
          rem      <= r_sh[31:0];
          quotient <= {quotient[46:0], 1'b0};
        end
        cnt <= cnt + 6'd1;
        if (cnt == 6'd47) begin
          busy <= 1'b0;
          done <= 1'b1;
        end
      end
    end
  end

endmodule
